[src/s1s2pw_pkg.sv]
// ----------------------------------------------------------------------------
// S1S2 pacing window timer package
// Register map, configuration record and fixed pacing constants.
// ----------------------------------------------------------------------------
package s1s2pw_pkg;

	// Number of beats between two interval decrement points.
	localparam logic [7:0] DECREMENT_PERIOD = 8'd5;
	// Intervals only shrink while the S2 interval is above this many ticks.
	localparam logic [23:0] MIN_CYCLE = 24'd640;

	localparam int unsigned ADDR_W = 5;

	// Register indexes, taken from paddr[4:2].
	localparam logic [2:0] REG_FIRST_START = 3'd0;
	localparam logic [2:0] REG_PULSE_WIDTH = 3'd1;
	localparam logic [2:0] REG_S1_INTERVAL = 3'd2;
	localparam logic [2:0] REG_S2_INTERVAL = 3'd3;
	localparam logic [2:0] REG_S1_COUNT    = 3'd4;
	localparam logic [2:0] REG_S2_COUNT    = 3'd5;
	localparam logic [2:0] REG_S1_STEP     = 3'd6;
	localparam logic [2:0] REG_S2_STEP     = 3'd7;

	typedef struct packed {
		logic [31:0] first_start;
		logic [23:0] pulse_width;
		logic [23:0] s1_interval;
		logic [23:0] s2_interval;
		logic [7:0]  s1_count;
		logic [7:0]  s2_count;
		logic [15:0] s1_step;
		logic [15:0] s2_step;
	} cfg_t;

endpackage

[src/s1s2pw_if.sv]
// ----------------------------------------------------------------------------
// S1S2 pacing window timer channels
// Valid/ready channels for time words and stimulus result words.
// ----------------------------------------------------------------------------
interface s1s2pw_time_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_now;

	modport source (output valid, output time_now, input ready);
	modport sink (input valid, input time_now, output ready);
endinterface

interface s1s2pw_stim_if;
	logic        valid;
	logic        ready;
	logic        stimulus_on;
	logic [31:0] window_open_time;

	modport source (output valid, output stimulus_on, output window_open_time, input ready);
	modport sink (input valid, input stimulus_on, input window_open_time, output ready);
endinterface

[src/s1s2pw_cfg_regs.sv]
// ----------------------------------------------------------------------------
// S1S2 pacing window timer configuration registers
// APB-style register file holding the eight pacing settings.
// ----------------------------------------------------------------------------
module s1s2pw_cfg_regs
	import s1s2pw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_start <= 32'd0;
			cfg_q.pulse_width <= 24'd64;
			cfg_q.s1_interval <= 24'd3840;
			cfg_q.s2_interval <= 24'd3840;
			cfg_q.s1_count    <= 8'd1;
			cfg_q.s2_count    <= 8'd1;
			cfg_q.s1_step     <= 16'd0;
			cfg_q.s2_step     <= 16'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FIRST_START: cfg_q.first_start <= pwdata;
				REG_PULSE_WIDTH: cfg_q.pulse_width <= pwdata[23:0];
				REG_S1_INTERVAL: cfg_q.s1_interval <= pwdata[23:0];
				REG_S2_INTERVAL: cfg_q.s2_interval <= pwdata[23:0];
				REG_S1_COUNT:    cfg_q.s1_count    <= pwdata[7:0];
				REG_S2_COUNT:    cfg_q.s2_count    <= pwdata[7:0];
				REG_S1_STEP:     cfg_q.s1_step     <= pwdata[15:0];
				REG_S2_STEP:     cfg_q.s2_step     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FIRST_START: prdata = cfg_q.first_start;
			REG_PULSE_WIDTH: prdata = {8'd0, cfg_q.pulse_width};
			REG_S1_INTERVAL: prdata = {8'd0, cfg_q.s1_interval};
			REG_S2_INTERVAL: prdata = {8'd0, cfg_q.s2_interval};
			REG_S1_COUNT:    prdata = {24'd0, cfg_q.s1_count};
			REG_S2_COUNT:    prdata = {24'd0, cfg_q.s2_count};
			REG_S1_STEP:     prdata = {16'd0, cfg_q.s1_step};
			REG_S2_STEP:     prdata = {16'd0, cfg_q.s2_step};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

[src/s1s2pw_beat_engine.sv]
// ----------------------------------------------------------------------------
// S1S2 pacing window timer beat engine
// Window and interval state with the beat update done in one pass of compares and adds.
// ----------------------------------------------------------------------------
module s1s2pw_beat_engine
	import s1s2pw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        fire,
	input  logic [31:0] time_now,
	output logic        stimulus_on,
	output logic [31:0] window_open_time
);

	logic        active_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [23:0] s1_iv_q;
	logic [23:0] s2_iv_q;
	logic [8:0]  pos_q;
	logic [7:0]  phase_q;

	logic [31:0] eff_start;
	logic [31:0] eff_end;
	logic [23:0] eff_s1;
	logic [23:0] eff_s2;
	logic        before_win;
	logic        beat;
	logic [8:0]  pos_inc;
	logic [7:0]  phase_inc;
	logic        dec_point;
	logic        do_shrink;
	logic [23:0] new_s1;
	logic [23:0] new_s2;
	logic [23:0] move;
	logic [31:0] moved_start;
	logic [31:0] moved_end;
	logic [8:0]  pattern_len;

	function automatic logic [23:0] shrink(input logic [23:0] cur, input logic [15:0] step);
		logic [23:0] step_w;
		step_w = {8'd0, step};
		return (cur > step_w) ? (cur - step_w) : 24'd1;
	endfunction

	// Before the first word the window and intervals come straight from configuration.
	assign eff_start = active_q ? start_q : cfg.first_start;
	assign eff_end   = active_q ? end_q : (cfg.first_start + {8'd0, cfg.pulse_width});
	assign eff_s1    = active_q ? s1_iv_q : cfg.s1_interval;
	assign eff_s2    = active_q ? s2_iv_q : cfg.s2_interval;

	assign before_win  = time_now < eff_start;
	assign beat        = !before_win && (time_now > eff_end);
	assign stimulus_on = !before_win && (time_now <= eff_end);

	assign pos_inc     = pos_q + 9'd1;
	assign phase_inc   = phase_q + 8'd1;
	assign dec_point   = phase_inc >= DECREMENT_PERIOD;
	assign do_shrink   = dec_point && (eff_s2 > MIN_CYCLE);
	assign new_s1      = do_shrink ? shrink(eff_s1, cfg.s1_step) : eff_s1;
	assign new_s2      = do_shrink ? shrink(eff_s2, cfg.s2_step) : eff_s2;
	assign move        = (pos_inc >= {1'b0, cfg.s1_count}) ? new_s2 : new_s1;
	assign moved_start = eff_start + {8'd0, move};
	assign moved_end   = eff_end + {8'd0, move};
	assign pattern_len = {1'b0, cfg.s1_count} + {1'b0, cfg.s2_count};

	assign window_open_time = beat ? moved_start : eff_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= 9'd0;
			phase_q  <= 8'd0;
		end else if (fire) begin
			active_q <= 1'b1;
			if (beat) begin
				pos_q   <= (pos_inc >= pattern_len) ? 9'd0 : pos_inc;
				phase_q <= dec_point ? 8'd0 : phase_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (beat) begin
				start_q <= moved_start;
				end_q   <= moved_end;
				s1_iv_q <= new_s1;
				s2_iv_q <= new_s2;
			end else begin
				start_q <= eff_start;
				end_q   <= eff_end;
				s1_iv_q <= eff_s1;
				s2_iv_q <= eff_s2;
			end
		end
	end

endmodule

[src/s1s2_pacing_window_timer_core.sv]
// ----------------------------------------------------------------------------
// S1S2 pacing window timer core
// Reports per time word whether the stimulus window is open and paces it.
// ----------------------------------------------------------------------------
// The block takes one time word per clock while results are accepted, and
// returns one result word per time word, in order. Each result says whether
// the time lies inside the current stimulus window (both ends included) and
// gives the window's start tick after this word's update. A time past the
// window counts as a beat: the window moves by the S1 or S2 interval according
// to the pattern position, and every fifth beat both intervals shrink by their
// steps while the S2 interval is above 640 ticks. A word passes through the
// input register and the result register, and a new word can be taken every
// cycle while results are accepted, because the whole window update is one
// pass of compares and adds on the stored state. The window start, pulse width
// and initial intervals are latched on the first word after reset; counts and
// steps act at once. Configuration must be written over the APB-style port
// only while no word is in flight; the block does not enforce this.
module s1s2_pacing_window_timer_core
	import s1s2pw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	s1s2pw_time_if.sink       tick,
	s1s2pw_stim_if.source     stim,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t        cfg;
	logic        valid_s1;
	logic [31:0] time_s1;
	logic        advance;
	logic        eng_on;
	logic [31:0] eng_open;
	logic        out_valid_q;
	logic        out_on_q;
	logic [31:0] out_open_q;

	s1s2pw_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The staged word moves on whenever the result register is empty or is
	// being emptied in the same cycle, so a waiting result never stalls intake
	// by more than the one word already staged.
	assign advance    = valid_s1 && (!out_valid_q || stim.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.valid && tick.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			time_s1 <= tick.time_now;
		end
	end

	// The engine's state is updated at the same edge that loads the result
	// register, so the next staged word sees the moved window.
	s1s2pw_beat_engine u_beat_engine (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.fire             (advance),
		.time_now         (time_s1),
		.stimulus_on      (eng_on),
		.window_open_time (eng_open)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (stim.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_on_q   <= eng_on;
			out_open_q <= eng_open;
		end
	end

	assign stim.valid            = out_valid_q;
	assign stim.stimulus_on      = out_on_q;
	assign stim.window_open_time = out_open_q;

endmodule
